@@ sv/ptsc_pkg.sv @@
// Shared constants for the pan/tilt tracking servo commander.
package ptsc_pkg;

  // Geometry and arithmetic widths
  localparam int COORD_BITS_DEF = 12;
  localparam int GAIN_BITS      = 16;
  localparam int POS_BITS       = 8;
  localparam int CHAN_BITS      = 3;
  localparam int BYTE_BITS      = 8;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_IDX_BITS   = 3;

  // Position limits
  localparam logic [POS_BITS-1:0] POS_MAX   = 8'd255;
  localparam logic [POS_BITS-1:0] POS_CAP   = 8'd254;
  localparam logic [POS_BITS-1:0] POS_RESET = 8'd128;

  // Command stream sync byte
  localparam logic [BYTE_BITS-1:0] SYNC_BYTE = 8'hFF;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN           = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAN_CHANNEL    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_TILT_CHANNEL   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_TILT_LOW_LIMIT = 3'd5;

  // Register reset values
  localparam int FRAME_WIDTH_RESET  = 640;
  localparam int FRAME_HEIGHT_RESET = 480;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET           = 16'd6554;
  localparam logic [CHAN_BITS-1:0] PAN_CHANNEL_RESET    = 3'd7;
  localparam logic [CHAN_BITS-1:0] TILT_CHANNEL_RESET   = 3'd0;
  localparam logic [POS_BITS-1:0]  TILT_LOW_LIMIT_RESET = 8'd75;

endpackage

@@ sv/pan_tilt_tracking_servo_commander.sv @@
// Top level: face box in, six-byte pan/tilt servo command out.
//
// Each accepted box with face_found set produces six output transfers in
// order: sync 255, pan channel, pan position, sync 255, tilt channel, tilt
// position (each position capped at 254), with last_byte set on the sixth.
// A face frame occupies the output for six transfers, one byte per cycle while
// out_ready_i is high. A box is first captured in the input register; its
// command is then loaded into the frame register and byte sequencer, which
// offers the first byte. Boxes without a face are absorbed and produce nothing.
// The input register holds one more box while the previous command is still
// draining, and a new command is loaded in the same cycle the last byte of
// the previous one transfers. Positions reset to 128 and update when a
// command is loaded; registers may be rewritten only while the block is idle.
module pan_tilt_tracking_servo_commander #(
  parameter int COORD_BITS = ptsc_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [ptsc_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [ptsc_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i,
  // Face box input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              face_found_i,
  input  logic [COORD_BITS-1:0]             box_x_i,
  input  logic [COORD_BITS-1:0]             box_y_i,
  input  logic [COORD_BITS-1:0]             box_w_i,
  input  logic [COORD_BITS-1:0]             box_h_i,
  // Serial command output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ptsc_pkg::BYTE_BITS-1:0]    serial_byte_o,
  output logic                              last_byte_o
);
  import ptsc_pkg::*;

  localparam int DW = COORD_BITS + 2;

  // Byte slots of one command frame
  localparam logic [2:0] SLOT_PAN_SYNC  = 3'd0;
  localparam logic [2:0] SLOT_PAN_CHAN  = 3'd1;
  localparam logic [2:0] SLOT_PAN_POS   = 3'd2;
  localparam logic [2:0] SLOT_TILT_SYNC = 3'd3;
  localparam logic [2:0] SLOT_TILT_CHAN = 3'd4;
  localparam logic [2:0] SLOT_TILT_POS  = 3'd5;

  // Configuration registers
  logic [COORD_BITS-1:0] frame_width_q, frame_height_q;
  logic [GAIN_BITS-1:0]  gain_q;
  logic [CHAN_BITS-1:0]  pan_channel_q, tilt_channel_q;
  logic [POS_BITS-1:0]   tilt_low_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q    <= COORD_BITS'(FRAME_WIDTH_RESET);
      frame_height_q   <= COORD_BITS'(FRAME_HEIGHT_RESET);
      gain_q           <= GAIN_RESET;
      pan_channel_q    <= PAN_CHANNEL_RESET;
      tilt_channel_q   <= TILT_CHANNEL_RESET;
      tilt_low_limit_q <= TILT_LOW_LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:    frame_width_q    <= cfg_wdata_i[COORD_BITS-1:0];
        REG_FRAME_HEIGHT:   frame_height_q   <= cfg_wdata_i[COORD_BITS-1:0];
        REG_GAIN:           gain_q           <= cfg_wdata_i[GAIN_BITS-1:0];
        REG_PAN_CHANNEL:    pan_channel_q    <= cfg_wdata_i[CHAN_BITS-1:0];
        REG_TILT_CHANNEL:   tilt_channel_q   <= cfg_wdata_i[CHAN_BITS-1:0];
        REG_TILT_LOW_LIMIT: tilt_low_limit_q <= cfg_wdata_i[POS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Handshake control
  logic       in_valid_q;
  logic       face_q;
  logic       busy_q;
  logic [2:0] slot_q;
  logic       ser_free;
  logic       in_adv;
  logic       load;

  assign ser_free   = !busy_q || (out_ready_i && (slot_q == SLOT_TILT_POS));
  assign in_adv     = in_valid_q && (!face_q || ser_free);
  assign load       = in_valid_q && face_q && ser_free;
  assign in_ready_o = !in_valid_q || in_adv;

  // Input register
  logic [COORD_BITS-1:0] box_x_q, box_y_q, box_w_q, box_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      face_q  <= face_found_i;
      box_x_q <= box_x_i;
      box_y_q <= box_y_i;
      box_w_q <= box_w_i;
      box_h_q <= box_h_i;
    end
  end

  // Offsets of the box center from the frame center
  logic [DW-1:0] dx, dy;

  assign dx = DW'(frame_width_q >> 1) - DW'(box_x_q) - DW'(box_w_q >> 1);
  assign dy = DW'(frame_height_q >> 1) - DW'(box_y_q) - DW'(box_h_q >> 1);

  // Position accumulators
  logic [POS_BITS-1:0] pan_q, tilt_q;
  logic [POS_BITS-1:0] pan_d, tilt_d;

  ptsc_step #(
    .COORD_BITS (COORD_BITS),
    .NEGATE     (1'b1)
  ) u_pan_step (
    .offset_i (dx),
    .gain_i   (gain_q),
    .pos_i    (pan_q),
    .low_i    ('0),
    .pos_o    (pan_d)
  );

  ptsc_step #(
    .COORD_BITS (COORD_BITS),
    .NEGATE     (1'b0)
  ) u_tilt_step (
    .offset_i (dy),
    .gain_i   (gain_q),
    .pos_i    (tilt_q),
    .low_i    (tilt_low_limit_q),
    .pos_o    (tilt_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_q  <= POS_RESET;
      tilt_q <= POS_RESET;
    end else if (load) begin
      pan_q  <= pan_d;
      tilt_q <= tilt_d;
    end
  end

  // Command frame register, capped position bytes
  logic [BYTE_BITS-1:0] pan_byte_q, tilt_byte_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      pan_byte_q  <= (pan_d > POS_CAP) ? POS_CAP : pan_d;
      tilt_byte_q <= (tilt_d > POS_CAP) ? POS_CAP : tilt_d;
    end
  end

  // Byte sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      slot_q <= SLOT_PAN_SYNC;
    end else if (load) begin
      busy_q <= 1'b1;
      slot_q <= SLOT_PAN_SYNC;
    end else if (busy_q && out_ready_i) begin
      if (slot_q == SLOT_TILT_POS) begin
        busy_q <= 1'b0;
        slot_q <= SLOT_PAN_SYNC;
      end else begin
        slot_q <= slot_q + 3'd1;
      end
    end
  end

  // Output byte select
  always_comb begin
    case (slot_q)
      SLOT_PAN_SYNC:  serial_byte_o = SYNC_BYTE;
      SLOT_PAN_CHAN:  serial_byte_o = BYTE_BITS'(pan_channel_q);
      SLOT_PAN_POS:   serial_byte_o = pan_byte_q;
      SLOT_TILT_SYNC: serial_byte_o = SYNC_BYTE;
      SLOT_TILT_CHAN: serial_byte_o = BYTE_BITS'(tilt_channel_q);
      SLOT_TILT_POS:  serial_byte_o = tilt_byte_q;
      default:        serial_byte_o = SYNC_BYTE;
    endcase
  end

  assign out_valid_o = busy_q;
  assign last_byte_o = (slot_q == SLOT_TILT_POS);

endmodule

@@ sv/ptsc_step.sv @@
// One axis: scale the offset by the Q0.16 gain, accumulate and clamp.
module ptsc_step #(
  parameter int COORD_BITS = ptsc_pkg::COORD_BITS_DEF,
  parameter bit NEGATE     = 1'b0
) (
  input  logic [COORD_BITS+1:0]          offset_i,
  input  logic [ptsc_pkg::GAIN_BITS-1:0] gain_i,
  input  logic [ptsc_pkg::POS_BITS-1:0]  pos_i,
  input  logic [ptsc_pkg::POS_BITS-1:0]  low_i,
  output logic [ptsc_pkg::POS_BITS-1:0]  pos_o
);
  import ptsc_pkg::*;

  localparam int DW = COORD_BITS + 2;          // signed offset width
  localparam int MW = DW - 1;                  // magnitude width
  localparam int PW = MW + GAIN_BITS;          // product width
  localparam int AW = COORD_BITS + 3;          // signed accumulator width

  logic          neg;
  logic [DW-1:0] neg_offset;
  logic [MW-1:0] mag;
  logic [PW-1:0] prod;
  logic [MW-1:0] step_mag;
  logic          sub;
  logic [AW-1:0] acc;

  // Magnitude of the offset, product truncated toward zero
  assign neg        = offset_i[DW-1];
  assign neg_offset = DW'(0) - offset_i;
  assign mag        = neg ? neg_offset[MW-1:0] : offset_i[MW-1:0];
  assign prod       = PW'(mag) * PW'(gain_i);
  assign step_mag   = prod[PW-1:GAIN_BITS];

  // Add or subtract the step magnitude depending on sign and axis direction
  assign sub = neg ^ NEGATE;
  assign acc = sub ? (AW'(pos_i) - AW'(step_mag)) : (AW'(pos_i) + AW'(step_mag));

  // Clamp to low..255
  always_comb begin
    if (acc[AW-1]) begin
      pos_o = low_i;
    end else if (acc[AW-2:0] > (AW-1)'(POS_MAX)) begin
      pos_o = POS_MAX;
    end else if (acc[POS_BITS-1:0] < low_i) begin
      pos_o = low_i;
    end else begin
      pos_o = acc[POS_BITS-1:0];
    end
  end

endmodule
